@@ hdl/mnm_pkg.sv @@
// package for the music note to midi event converter
// holds command, control and event codes plus shared constants; no dependencies
package mnm_pkg;

  localparam int unsigned MaxChordDef = 8;
  localparam int unsigned MaxDotsDef  = 3;

  localparam logic [1:0] CmdNote  = 2'd0;
  localparam logic [1:0] CmdCtl   = 2'd1;
  localparam logic [1:0] CmdEnd   = 2'd2;
  localparam logic [1:0] CmdStart = 2'd3;

  localparam logic [2:0] OpTempo  = 3'd0;
  localparam logic [2:0] OpOctave = 3'd1;
  localparam logic [2:0] OpVel    = 3'd2;
  localparam logic [2:0] OpDefLen = 3'd3;
  localparam logic [2:0] OpOctUp  = 3'd4;
  localparam logic [2:0] OpOctDn  = 3'd5;

  localparam logic [1:0] EvNoteOn  = 2'd0;
  localparam logic [1:0] EvNoteOff = 2'd1;
  localparam logic [1:0] EvTempo   = 2'd2;
  localparam logic [1:0] EvEnd     = 2'd3;

  localparam logic CfgTpq  = 1'b0;
  localparam logic CfgChan = 1'b1;

  localparam logic [25:0] TempoNum     = 26'd60000000;
  localparam logic [23:0] TempoDefault = 24'd500000;
  localparam logic [23:0] TempoMax     = 24'hFFFFFF;

  // one divide request for the shared serial divider
  typedef struct packed {
    logic        start;
    logic [25:0] num;
    logic [9:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [25:0] quo;
  } div_rsp_t;

  // semitone offset of a pitch letter
  function automatic logic [3:0] letter_off(input logic [2:0] l);
    logic [3:0] r;
    r = 4'd0;
    case (l)
      3'd0: r = 4'd0;
      3'd1: r = 4'd2;
      3'd2: r = 4'd4;
      3'd3: r = 4'd5;
      3'd4: r = 4'd7;
      3'd5: r = 4'd9;
      3'd6: r = 4'd11;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/mnm_div.sv @@
// restoring serial divider, one quotient bit per cycle
// depends on mnm_pkg for the request and response types
module mnm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mnm_pkg::div_req_t req_i,
  output mnm_pkg::div_rsp_t rsp_o
);

  logic [25:0] quo_q, quo_d;
  logic [9:0]  den_q, den_d;
  logic [10:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [10:0] shifted;
  logic [11:0] diff;

  // load a new request, or take one shift and subtract step while busy
  always_comb begin
    shifted = {rem_q[9:0], quo_q[25]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    quo_d   = quo_q;
    den_d   = den_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (diff[11]) begin
        rem_d = shifted;
        quo_d = {quo_q[24:0], 1'b0};
      end else begin
        rem_d = diff[10:0];
        quo_d = {quo_q[24:0], 1'b1};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd25) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ hdl/music_notes_to_midi_events.sv @@
// Converts notation items into MIDI-style events. A note item that ends a chord runs its duration
// divide (one serial 26-bit divider shared with tempo), then each chord entry is read in a
// note-on pass and again in a note-off pass, from the chord memory and the 128-entry
// sounding memory (synchronous reads). Note events pass through a one-entry hold so
// the final one of an item can carry last; it is released at the end of the item. Track
// start and reset sweep all 128 entries of the sounding memory clear, during which no
// item is accepted. Each result waits in an output register until taken.
// depends on mnm_pkg and mnm_div
module music_notes_to_midi_events #(
  parameter int unsigned MAX_CHORD = mnm_pkg::MaxChordDef,
  parameter int unsigned MAX_DOTS  = mnm_pkg::MaxDotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [2:0]  pitch_letter_i,
  input  logic signed [2:0] accidental_i,
  input  logic        tie_i,
  input  logic        chord_link_i,
  input  logic [6:0]  note_length_i,
  input  logic [1:0]  dots_i,
  input  logic [2:0]  ctl_op_i,
  input  logic [9:0]  ctl_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_kind_o,
  output logic [31:0] delta_ticks_o,
  output logic [3:0]  channel_out_o,
  output logic [6:0]  note_number_o,
  output logic [6:0]  velocity_out_o,
  output logic [23:0] tempo_us_o,
  output logic        last_o
);

  localparam int unsigned CW = (MAX_CHORD > 1) ? $clog2(MAX_CHORD) : 1;
  localparam int unsigned NW = $clog2(MAX_CHORD + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_ON_RD, S_ON_EV, S_OFF_RD, S_OFF_EV, S_CTL, S_WAIT
  } state_e;

  state_e      st_q;
  logic [15:0] tpq_q;
  logic [3:0]  chan_q;
  logic [3:0]  oct_q;
  logic [6:0]  vel_q;
  logic [6:0]  dlen_q;
  logic [31:0] cur_q, lastt_q;
  logic [NW-1:0] cnt_q;
  logic [NW-1:0] idx_q;
  logic [6:0]  clr_q;
  logic [31:0] dur_q;
  logic [1:0]  dots_q;
  logic [1:0]  cmd_q;
  logic [2:0]  op_q;
  logic [9:0]  val_q;
  logic [23:0] tempo_q;
  logic        any_q;
  logic        ret_q;

  // held note event, released once the next event or the end of the item is known
  logic [1:0]  hk_q;
  logic [31:0] hd_q;
  logic [6:0]  hn_q;
  logic [6:0]  hv_q;

  // chord and sounding memories
  logic [7:0]  chord_mem [MAX_CHORD];
  logic [7:0]  chord_rd_q;
  logic        snd_mem [128];
  logic        snd_rd_q;
  logic        snd_we;
  logic [6:0]  snd_wa;
  logic        snd_wd;
  logic        ch_we;
  logic [CW-1:0] ch_wa;
  logic [7:0]  ch_wd;

  // output register
  logic        ov_q;
  logic [1:0]  ok_q;
  logic [31:0] od_q;
  logic [3:0]  oc_q;
  logic [6:0]  on_q;
  logic [6:0]  ovl_q;
  logic [23:0] ot_q;
  logic        ol_q;

  mnm_pkg::div_req_t dreq;
  mnm_pkg::div_rsp_t drsp;

  mnm_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  logic in_acc;
  assign in_ready_o  = (st_q == S_IDLE) && !ov_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // item ends with its own tempo or end-of-track event
  logic tail_ev;
  assign tail_ev = (cmd_q == mnm_pkg::CmdEnd)
                || (cmd_q == mnm_pkg::CmdCtl && op_q == mnm_pkg::OpTempo && val_q != 10'd0);

  // note number of the incoming note
  logic signed [8:0] nn_raw;
  logic [6:0]        nn;
  always_comb begin
    nn_raw = $signed({5'd0, oct_q} + 9'sd1) * 9'sd12
           + $signed({5'd0, mnm_pkg::letter_off(pitch_letter_i)})
           + 9'(accidental_i);
    if (nn_raw < 0) nn = 7'd0;
    else if (nn_raw > 9'sd127) nn = 7'd127;
    else nn = nn_raw[6:0];
  end

  logic [6:0] eff_len;
  assign eff_len = (note_length_i == 7'd0) ? dlen_q : note_length_i;

  // duration with dots from the divider quotient
  logic [31:0] base, tot, add;
  logic [2:0]  nd;
  always_comb begin
    base = {6'd0, drsp.quo};
    nd   = ({1'b0, dots_q} > 3'(MAX_DOTS)) ? 3'(MAX_DOTS) : {1'b0, dots_q};
    tot  = base;
    add  = base;
    for (int i = 0; i < 3; i++) begin
      if (3'(i) < nd) begin
        add = add >> 1;
        tot = tot + add;
      end
    end
  end

  logic out_free;
  assign out_free = !ov_q || out_ready_i;
  logic [CW-1:0] idx_c;
  assign idx_c = idx_q[CW-1:0];

  always_comb begin
    dreq       = '0;
    snd_we     = 1'b0;
    snd_wa     = chord_rd_q[6:0];
    snd_wd     = 1'b0;
    ch_we      = 1'b0;
    ch_wa      = cnt_q[CW-1:0];
    ch_wd      = {tie_i, nn};
    if (st_q == S_CLEAR) begin
      snd_we = 1'b1;
      snd_wa = clr_q;
    end
    if (in_acc && cmd_i == mnm_pkg::CmdNote && pitch_letter_i != 3'd7
        && cnt_q < NW'(MAX_CHORD))
      ch_we = 1'b1;
    if (in_acc && cmd_i == mnm_pkg::CmdNote && !chord_link_i && eff_len != 7'd0) begin
      dreq.start = 1'b1;
      dreq.num   = {8'd0, tpq_q, 2'b00};
      dreq.den   = {3'd0, eff_len};
    end
    if (in_acc && cmd_i == mnm_pkg::CmdCtl && ctl_op_i == mnm_pkg::OpTempo
        && ctl_value_i != 10'd0) begin
      dreq.start = 1'b1;
      dreq.num   = mnm_pkg::TempoNum;
      dreq.den   = ctl_value_i;
    end
    if (st_q == S_ON_EV && out_free && !snd_rd_q) begin
      snd_we = 1'b1;
      snd_wd = 1'b1;
    end
    if (st_q == S_OFF_EV && out_free && !chord_rd_q[7])
      snd_we = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) chord_mem[ch_wa] <= ch_wd;
    chord_rd_q <= chord_mem[idx_c];
    if (snd_we) snd_mem[snd_wa] <= snd_wd;
    snd_rd_q <= snd_mem[chord_mem[idx_c][6:0]];
  end

  // control sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR; tpq_q <= 16'd480; chan_q <= '0; oct_q <= 4'd4; vel_q <= 7'd100;
      dlen_q <= 7'd4; cur_q <= '0; lastt_q <= '0; cnt_q <= '0; idx_q <= '0; clr_q <= '0;
      dur_q <= '0; dots_q <= '0; cmd_q <= '0; op_q <= '0; val_q <= '0; any_q <= 1'b0;
      tempo_q <= '0; hk_q <= '0; hd_q <= '0; hn_q <= '0; hv_q <= '0;
      ret_q <= 1'b0; ov_q <= 1'b0; ok_q <= '0; od_q <= '0; oc_q <= '0; on_q <= '0;
      ovl_q <= '0; ot_q <= '0; ol_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == mnm_pkg::CfgTpq) tpq_q <= cfg_data_i;
        else chan_q <= cfg_data_i[3:0];
      end
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (st_q)
        S_CLEAR: begin
          clr_q <= clr_q + 7'd1;
          if (clr_q == 7'd127) begin
            st_q <= S_IDLE;
            if (ret_q) begin
              ret_q <= 1'b0;
              ov_q <= 1'b1; ok_q <= mnm_pkg::EvTempo; od_q <= '0; oc_q <= '0;
              on_q <= '0; ovl_q <= '0; ot_q <= mnm_pkg::TempoDefault; ol_q <= 1'b1;
            end
          end
        end
        S_IDLE: if (in_acc) begin
          cmd_q <= cmd_i; op_q <= ctl_op_i; val_q <= ctl_value_i; dots_q <= dots_i;
          idx_q <= '0; any_q <= 1'b0; dur_q <= '0;
          if (ch_we) cnt_q <= cnt_q + NW'(1);
          case (cmd_i)
            mnm_pkg::CmdNote: begin
              if (!chord_link_i) st_q <= (eff_len != 7'd0) ? S_DIV : S_ON_RD;
            end
            mnm_pkg::CmdStart: begin
              cnt_q <= '0; cur_q <= '0; lastt_q <= '0; oct_q <= 4'd4; vel_q <= 7'd100;
              dlen_q <= 7'd4; clr_q <= '0; ret_q <= 1'b1; st_q <= S_CLEAR;
            end
            default: st_q <= (ctl_op_i == mnm_pkg::OpTempo && cmd_i == mnm_pkg::CmdCtl
                              && ctl_value_i != 10'd0) ? S_DIV : S_ON_RD;
          endcase
        end
        S_DIV: if (drsp.done) begin
          if (cmd_q == mnm_pkg::CmdNote) dur_q <= tot;
          else tempo_q <= (drsp.quo > 26'(mnm_pkg::TempoMax)) ? mnm_pkg::TempoMax
                                                               : drsp.quo[23:0];
          st_q <= S_ON_RD;
        end
        S_ON_RD: begin
          if (idx_q == cnt_q) begin
            cur_q <= cur_q + dur_q; idx_q <= '0; st_q <= S_OFF_RD;
          end else st_q <= S_ON_EV;
        end
        S_ON_EV: if (out_free) begin
          if (!snd_rd_q) begin
            if (any_q) begin
              ov_q <= 1'b1; ok_q <= hk_q; od_q <= hd_q; oc_q <= chan_q; on_q <= hn_q;
              ovl_q <= hv_q; ot_q <= '0; ol_q <= 1'b0;
            end
            hk_q <= mnm_pkg::EvNoteOn; hd_q <= cur_q - lastt_q; lastt_q <= cur_q;
            hn_q <= chord_rd_q[6:0]; hv_q <= vel_q; any_q <= 1'b1;
          end
          idx_q <= idx_q + NW'(1); st_q <= S_ON_RD;
        end
        S_OFF_RD: begin
          if (idx_q == cnt_q) begin
            cnt_q <= '0; st_q <= S_CTL;
          end else st_q <= S_OFF_EV;
        end
        S_OFF_EV: if (out_free) begin
          if (!chord_rd_q[7]) begin
            if (any_q) begin
              ov_q <= 1'b1; ok_q <= hk_q; od_q <= hd_q; oc_q <= chan_q; on_q <= hn_q;
              ovl_q <= hv_q; ot_q <= '0; ol_q <= 1'b0;
            end
            hk_q <= mnm_pkg::EvNoteOff; hd_q <= cur_q - lastt_q; lastt_q <= cur_q;
            hn_q <= chord_rd_q[6:0]; hv_q <= '0; any_q <= 1'b1;
          end
          idx_q <= idx_q + NW'(1); st_q <= S_OFF_RD;
        end
        S_CTL: if (out_free) begin
          if (any_q) begin
            // release the held note event, last only when nothing follows it
            ov_q <= 1'b1; ok_q <= hk_q; od_q <= hd_q; oc_q <= chan_q; on_q <= hn_q;
            ovl_q <= hv_q; ot_q <= '0; ol_q <= !tail_ev; any_q <= 1'b0;
            if (!tail_ev) st_q <= S_WAIT;
          end else if (cmd_q == mnm_pkg::CmdEnd) begin
            ov_q <= 1'b1; ok_q <= mnm_pkg::EvEnd; od_q <= '0; oc_q <= '0; on_q <= '0;
            ovl_q <= '0; ot_q <= '0; ol_q <= 1'b1; st_q <= S_WAIT;
          end else if (tail_ev) begin
            ov_q <= 1'b1; ok_q <= mnm_pkg::EvTempo; od_q <= cur_q - lastt_q;
            lastt_q <= cur_q; oc_q <= '0; on_q <= '0; ovl_q <= '0; ot_q <= tempo_q;
            ol_q <= 1'b1; st_q <= S_WAIT;
          end else begin
            st_q <= S_WAIT;
          end
          // control effects, applied once on the way out
          if (cmd_q == mnm_pkg::CmdCtl) begin
            case (op_q)
              mnm_pkg::OpOctave: oct_q <= (val_q > 10'd10) ? 4'd10 : val_q[3:0];
              mnm_pkg::OpVel: begin
                vel_q <= (val_q >= 10'd1016) ? 7'(val_q - 10'd1016)
                       : (val_q >= 10'd889) ? 7'(val_q - 10'd889)
                       : (val_q >= 10'd762) ? 7'(val_q - 10'd762)
                       : (val_q >= 10'd635) ? 7'(val_q - 10'd635)
                       : (val_q >= 10'd508) ? 7'(val_q - 10'd508)
                       : (val_q >= 10'd381) ? 7'(val_q - 10'd381)
                       : (val_q >= 10'd254) ? 7'(val_q - 10'd254)
                       : (val_q >= 10'd127) ? 7'(val_q - 10'd127) : val_q[6:0];
              end
              mnm_pkg::OpDefLen: dlen_q <= (val_q > 10'd127) ? 7'd127 : val_q[6:0];
              mnm_pkg::OpOctUp: if (oct_q < 4'd10) oct_q <= oct_q + 4'd1;
              mnm_pkg::OpOctDn: if (oct_q != 4'd0) oct_q <= oct_q - 4'd1;
              default: ;
            endcase
          end
        end
        S_WAIT: if (out_free) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = ov_q;
  assign event_kind_o   = ok_q;
  assign delta_ticks_o  = od_q;
  assign channel_out_o  = oc_q;
  assign note_number_o  = on_q;
  assign velocity_out_o = ovl_q;
  assign tempo_us_o     = ot_q;
  assign last_o         = ol_q;

`ifndef SYNTHESIS
  a_no_in_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> st_q == S_IDLE) else $error("input taken while busy");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(MAX_CHORD)) else $error("chord count overflow");
  a_end_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o == mnm_pkg::EvEnd) |-> delta_ticks_o == '0)
    else $error("end of track with nonzero delta");
  a_off_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o != mnm_pkg::EvNoteOn) |-> velocity_out_o == '0)
    else $error("velocity on non note-on event");
`endif

endmodule

@@ tb/sv/music_notes_to_midi_events_checker.sv @@
// event checker for the music note to midi event converter
// mirrors the converter state, predicts every event per accepted item and compares
// depends on mnm_pkg
`timescale 1ns / 100ps

module music_notes_to_midi_events_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  cmd_i,
  input  logic [2:0]  pitch_letter_i,
  input  logic signed [2:0] accidental_i,
  input  logic        tie_i,
  input  logic        chord_link_i,
  input  logic [6:0]  note_length_i,
  input  logic [1:0]  dots_i,
  input  logic [2:0]  ctl_op_i,
  input  logic [9:0]  ctl_value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  event_kind_i,
  input  logic [31:0] delta_ticks_i,
  input  logic [3:0]  channel_out_i,
  input  logic [6:0]  note_number_i,
  input  logic [6:0]  velocity_out_i,
  input  logic [23:0] tempo_us_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] delta;
    logic [3:0]  chan;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [23:0] tempo;
    logic        last;
  } exp_event_t;

  exp_event_t events_due[$];

  // mirrored converter state
  logic [15:0] tpq;
  logic [3:0]  chan;
  logic [3:0]  octave;
  logic [6:0]  velocity;
  logic [6:0]  def_len;
  logic [31:0] now_tick;
  logic [31:0] prev_tick;
  logic [127:0] sounding;
  logic [7:0]  chord_notes [mnm_pkg::MaxChordDef];
  int unsigned chord_len;

  assign pending_o = events_due.size();

  function automatic logic [31:0] tick_delta(input logic [31:0] t);
    logic [31:0] d;
    d = t - prev_tick;
    prev_tick = t;
    return d;
  endfunction

  function automatic void push_event(input logic [1:0] k, input logic [31:0] d,
                                     input logic [3:0] c, input logic [6:0] n,
                                     input logic [6:0] v, input logic [23:0] t);
    exp_event_t e;
    e = '{kind: k, delta: d, chan: c, note: n, vel: v, tempo: t, last: 1'b0};
    events_due.push_back(e);
  endfunction

  function automatic logic [31:0] note_ticks(input logic [6:0] len_in, input logic [1:0] nd);
    logic [31:0] len, base, total, add;
    len = (len_in == 0) ? 32'(def_len) : 32'(len_in);
    if (len == 0) return '0;
    base = (32'(tpq) * 4) / len;
    total = base;
    add = base;
    for (int i = 0; i < nd && i < mnm_pkg::MaxDotsDef; i++) begin
      add = add / 2;
      total = total + add;
    end
    return total;
  endfunction

  // note-ons for new notes, advance time, note-offs for untied notes
  function automatic void play_chord(input logic [31:0] dur);
    for (int i = 0; i < chord_len; i++) begin
      if (!sounding[chord_notes[i][6:0]]) begin
        push_event(mnm_pkg::EvNoteOn, tick_delta(now_tick), chan, chord_notes[i][6:0],
                   velocity, '0);
        sounding[chord_notes[i][6:0]] = 1'b1;
      end
    end
    now_tick = now_tick + dur;
    for (int i = 0; i < chord_len; i++) begin
      if (!chord_notes[i][7]) begin
        push_event(mnm_pkg::EvNoteOff, tick_delta(now_tick), chan, chord_notes[i][6:0],
                   '0, '0);
        sounding[chord_notes[i][6:0]] = 1'b0;
      end
    end
    chord_len = 0;
  endfunction

  function automatic void predict_item();
    int unsigned base_n;
    int note;
    logic [31:0] t;
    base_n = events_due.size();
    case (cmd_i)
      mnm_pkg::CmdNote: begin
        if (pitch_letter_i < 7 && chord_len < mnm_pkg::MaxChordDef) begin
          note = (int'(octave) + 1) * 12 + int'(mnm_pkg::letter_off(pitch_letter_i))
                 + int'(accidental_i);
          if (note < 0) note = 0;
          if (note > 127) note = 127;
          chord_notes[chord_len] = {tie_i, 7'(note)};
          chord_len++;
        end
        if (!chord_link_i) play_chord(note_ticks(note_length_i, dots_i));
      end
      mnm_pkg::CmdCtl: begin
        play_chord('0);
        case (ctl_op_i)
          mnm_pkg::OpTempo: if (ctl_value_i != 0) begin
            t = 32'd60000000 / 32'(ctl_value_i);
            if (t > 32'(mnm_pkg::TempoMax)) t = 32'(mnm_pkg::TempoMax);
            push_event(mnm_pkg::EvTempo, tick_delta(now_tick), '0, '0, '0, t[23:0]);
          end
          mnm_pkg::OpOctave: octave = (ctl_value_i > 10) ? 4'd10 : ctl_value_i[3:0];
          mnm_pkg::OpVel:    velocity = 7'(ctl_value_i % 127);
          mnm_pkg::OpDefLen: def_len = (ctl_value_i > 127) ? 7'd127 : ctl_value_i[6:0];
          mnm_pkg::OpOctUp:  if (octave < 10) octave++;
          mnm_pkg::OpOctDn:  if (octave > 0) octave--;
          default: ;
        endcase
      end
      mnm_pkg::CmdEnd: begin
        play_chord('0);
        push_event(mnm_pkg::EvEnd, '0, '0, '0, '0, '0);
      end
      default: begin
        chord_len = 0;
        sounding = '0;
        now_tick = '0;
        prev_tick = '0;
        octave = 4'd4;
        velocity = 7'd100;
        def_len = 7'd4;
        push_event(mnm_pkg::EvTempo, '0, '0, '0, '0, mnm_pkg::TempoDefault);
      end
    endcase
    if (events_due.size() > base_n) events_due[events_due.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: event %s mismatch: got %0d, want %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // watch the channels
  always @(posedge clk_i or negedge rst_ni) begin
    exp_event_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      tpq = 16'd480;
      chan = 4'd0;
      octave = 4'd4;
      velocity = 7'd100;
      def_len = 7'd4;
      now_tick = '0;
      prev_tick = '0;
      sounding = '0;
      chord_len = 0;
      events_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (events_due.size() == 0) begin
          report_mismatch("presence", 32'd1, 32'd0);
        end else begin
          want = events_due.pop_front();
          if (event_kind_i != want.kind) report_mismatch("kind", event_kind_i, want.kind);
          if (delta_ticks_i != want.delta) report_mismatch("delta", delta_ticks_i, want.delta);
          if (channel_out_i != want.chan) report_mismatch("channel", channel_out_i, want.chan);
          if (note_number_i != want.note) report_mismatch("note", note_number_i, want.note);
          if (velocity_out_i != want.vel) report_mismatch("velocity", velocity_out_i, want.vel);
          if (tempo_us_i != want.tempo) report_mismatch("tempo", tempo_us_i, want.tempo);
          if (last_i != want.last) report_mismatch("last", last_i, want.last);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == mnm_pkg::CfgTpq) tpq = cfg_data_i;
        else chan = cfg_data_i[3:0];
      end
      if (in_valid_i && in_ready_i) predict_item();
    end
  end
endmodule

@@ tb/sv/music_notes_to_midi_events_tb.sv @@
// testbench top for the music note to midi event converter
// drives items and register writes, gives the verdict; uses the checker and mnm_pkg
`timescale 1ns / 100ps

module music_notes_to_midi_events_tb;

  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0, cfg_ready_o, cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0, in_ready_o;
  logic [1:0] cmd_i = '0;
  logic [2:0] pitch_letter_i = '0;
  logic signed [2:0] accidental_i = '0;
  logic tie_i = 1'b0, chord_link_i = 1'b0;
  logic [6:0] note_length_i = '0;
  logic [1:0] dots_i = '0;
  logic [2:0] ctl_op_i = '0;
  logic [9:0] ctl_value_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic [1:0] event_kind_o;
  logic [31:0] delta_ticks_o;
  logic [3:0] channel_out_o;
  logic [6:0] note_number_o, velocity_out_o;
  logic [23:0] tempo_us_o;
  logic last_o;
  int fail_count, pending;
  int idle_cycles = 0;
  bit quiet_tail = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  music_notes_to_midi_events dut (.*);

  music_notes_to_midi_events_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .pitch_letter_i, .accidental_i, .tie_i,
    .chord_link_i, .note_length_i, .dots_i, .ctl_op_i, .ctl_value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .event_kind_i(event_kind_o),
    .delta_ticks_i(delta_ticks_o), .channel_out_i(channel_out_o),
    .note_number_i(note_number_o), .velocity_out_i(velocity_out_o),
    .tempo_us_i(tempo_us_o), .last_i(last_o), .fail_count_o(fail_count),
    .pending_o(pending));

  // watchdog on cycles with no accepted item, event or register write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver with bursts of back-pressure
  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 19);
        out_ready_i <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // valid stays up across back-to-back items and drops only before an idle gap
  task automatic send_item(input logic [1:0] c, input logic [2:0] l, input logic [2:0] a,
                           input logic t, input logic k, input logic [6:0] len,
                           input logic [1:0] d, input logic [2:0] op, input logic [9:0] v);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    cmd_i <= c; pitch_letter_i <= l; accidental_i <= a; tie_i <= t; chord_link_i <= k;
    note_length_i <= len; dots_i <= d; ctl_op_i <= op; ctl_value_i <= v;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_note(input logic [2:0] l, input logic t, input logic k,
                           input logic [6:0] len, input logic [1:0] d);
    send_item(mnm_pkg::CmdNote, l, 3'($urandom_range(0, 7)), t, k, len, d,
              3'($urandom), 10'($urandom));
  endtask

  task automatic send_ctl(input logic [2:0] op, input logic [9:0] v);
    send_item(mnm_pkg::CmdCtl, 3'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
              7'($urandom), 2'($urandom), op, v);
  endtask

  // stop sending, drain every event, then let a cycle budget pass before a register write
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // one random phrase: mostly notes and chords, some controls, occasional end and start items
  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      send_note(3'($urandom_range(0, 7)), 1'($urandom_range(0, 3) == 0),
                1'($urandom_range(0, 2) == 0),
                ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'(1 << $urandom_range(0, 6)),
                2'($urandom));
    end else if (pick < 90) begin
      send_ctl(3'($urandom_range(0, 7)),
               $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 12)));
    end else if (pick < 96) begin
      send_item(mnm_pkg::CmdEnd, 3'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
                7'($urandom), 2'($urandom), 3'($urandom), 10'($urandom));
    end else begin
      send_item(mnm_pkg::CmdStart, 3'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
                7'($urandom), 2'($urandom), 3'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of pitch, chords, dots, every control
    send_item(mnm_pkg::CmdStart, 0, 0, 0, 0, 0, 0, 0, 0);
    send_note(0, 0, 0, 1, 0);
    send_item(mnm_pkg::CmdNote, 6, 3'sd3, 0, 0, 64, 3, 0, 10'h3ff);
    send_item(mnm_pkg::CmdNote, 0, -3'sd3, 0, 0, 127, 2, 0, 0);
    send_note(7, 0, 0, 4, 1);
    for (int i = 0; i < 9; i++) send_note(3'(i % 7), 1'(i == 2), 1, 8, 0);
    send_note(2, 0, 0, 0, 3);
    send_note(4, 1, 0, 16, 0);
    send_note(4, 0, 0, 16, 0);
    send_ctl(mnm_pkg::OpTempo, 0);
    send_ctl(mnm_pkg::OpTempo, 1);
    send_ctl(mnm_pkg::OpTempo, 10'h3ff);
    send_ctl(mnm_pkg::OpOctave, 10'h3ff);
    send_note(6, 0, 1, 2, 0);
    send_note(6, 0, 0, 2, 0);
    send_ctl(mnm_pkg::OpOctUp, 0);
    send_ctl(mnm_pkg::OpOctave, 0);
    send_ctl(mnm_pkg::OpOctDn, 0);
    send_note(0, 0, 1, 4, 0);
    send_ctl(mnm_pkg::OpVel, 10'd1016);
    send_ctl(mnm_pkg::OpDefLen, 10'h3ff);
    send_ctl(mnm_pkg::OpDefLen, 0);
    send_note(1, 0, 0, 0, 0);
    send_ctl(3'd6, 5);
    send_item(mnm_pkg::CmdEnd, 0, 0, 0, 0, 0, 0, 0, 0);

    // random phases across register settings, sender waits for drain each time
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin write_reg(mnm_pkg::CfgTpq, 16'd1); write_reg(mnm_pkg::CfgChan, 16'd15); end
        1: begin write_reg(mnm_pkg::CfgTpq, 16'hffff); write_reg(mnm_pkg::CfgChan, 16'd0); end
        2: begin write_reg(mnm_pkg::CfgTpq, 16'($urandom_range(1, 65535)));
                 write_reg(mnm_pkg::CfgChan, 16'($urandom_range(0, 15))); end
        default: begin write_reg(mnm_pkg::CfgTpq, 16'd480);
                       write_reg(mnm_pkg::CfgChan, 16'hfff5);
                       quiet_tail = 1'b1; end
      endcase
      cfg_valid_i <= 1'b0;
      for (int i = 0; i < 22; i++) random_item();
    end
    send_item(mnm_pkg::CmdEnd, 0, 0, 0, 0, 0, 0, 0, 0);
    in_valid_i <= 1'b0;

    // drain, then allow the block's own latency
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/mnm_pkg.sv
hdl/mnm_div.sv
hdl/music_notes_to_midi_events.sv
tb/sv/music_notes_to_midi_events_checker.sv
tb/sv/music_notes_to_midi_events_tb.sv
